>>> rtl/sclp_pkg.sv
`timescale 1ns / 1ps

package sclp_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_T    = 3'd1,
    MODE_D    = 3'd2,
    MODE_B    = 3'd3,
    MODE_W    = 3'd4,
    MODE_R    = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_THRESH = 3'd1,
    ACT_SLEEP  = 3'd2,
    ACT_SWRITE = 3'd3,
    ACT_SREAD  = 3'd4
  } action_t;

  localparam logic [7:0]  CHAR_LF    = 8'h0a;
  localparam logic [7:0]  CHAR_CR    = 8'h0d;
  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;
  localparam logic [7:0]  CHAR_T     = 8'h74;
  localparam logic [7:0]  CHAR_D     = 8'h64;
  localparam logic [7:0]  CHAR_B     = 8'h62;
  localparam logic [7:0]  CHAR_W     = 8'h77;
  localparam logic [7:0]  CHAR_R     = 8'h72;
  localparam logic [15:0] VALUE_MAX  = 16'hffff;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] acc;
    logic [7:0]  pend;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]  echo_byte;
    action_t     action;
    logic [15:0] action_value;
    logic [7:0]  sensor_addr;
    logic [7:0]  sensor_data;
  } parse_result_t;

endpackage

>>> rtl/sclp_step.sv
`timescale 1ns / 1ps

module sclp_step (
  input  sclp_pkg::parse_state_t  cur,
  input  logic [7:0]              rx_byte,
  output sclp_pkg::parse_state_t  nxt,
  output sclp_pkg::parse_result_t res
);

  logic        eol;
  logic        digit;
  logic [15:0] acc_times_ten;
  logic [15:0] digit_value;

  assign eol           = (rx_byte == sclp_pkg::CHAR_LF) || (rx_byte == sclp_pkg::CHAR_CR);
  assign digit         = (rx_byte >= sclp_pkg::CHAR_ZERO) && (rx_byte <= sclp_pkg::CHAR_NINE);
  // x*10 as x*8 + x*2, wrapping at 16 bits
  assign acc_times_ten = {cur.acc[12:0], 3'b000} + {cur.acc[14:0], 1'b0};
  assign digit_value   = {8'h00, rx_byte - sclp_pkg::CHAR_ZERO};

  always_comb begin
    nxt                = cur;
    res.echo_byte      = rx_byte;
    res.action         = sclp_pkg::ACT_NONE;
    res.action_value   = '0;
    res.sensor_addr    = '0;
    res.sensor_data    = '0;
    unique case (cur.mode)
      sclp_pkg::MODE_T, sclp_pkg::MODE_D, sclp_pkg::MODE_B,
      sclp_pkg::MODE_W, sclp_pkg::MODE_R: begin
        if (eol) begin
          nxt.mode = sclp_pkg::MODE_IDLE;
          nxt.acc  = '0;
          unique case (cur.mode)
            sclp_pkg::MODE_T: begin
              res.action       = sclp_pkg::ACT_THRESH;
              res.action_value = cur.acc;
            end
            sclp_pkg::MODE_D: begin
              res.action       = sclp_pkg::ACT_SLEEP;
              res.action_value = sclp_pkg::VALUE_MAX - cur.acc;
            end
            sclp_pkg::MODE_B: begin
              nxt.pend = cur.acc[7:0];
            end
            sclp_pkg::MODE_W: begin
              res.action      = sclp_pkg::ACT_SWRITE;
              res.sensor_addr = cur.acc[7:0];
              res.sensor_data = cur.pend;
            end
            default: begin
              res.action      = sclp_pkg::ACT_SREAD;
              res.sensor_addr = cur.acc[7:0];
            end
          endcase
        end else if (digit) begin
          nxt.acc = acc_times_ten + digit_value;
        end
      end
      default: begin
        // idle, and the unused mode codes
        unique case (rx_byte)
          sclp_pkg::CHAR_T: nxt.mode = sclp_pkg::MODE_T;
          sclp_pkg::CHAR_D: nxt.mode = sclp_pkg::MODE_D;
          sclp_pkg::CHAR_B: nxt.mode = sclp_pkg::MODE_B;
          sclp_pkg::CHAR_W: nxt.mode = sclp_pkg::MODE_W;
          sclp_pkg::CHAR_R: nxt.mode = sclp_pkg::MODE_R;
          default:          nxt.mode = sclp_pkg::MODE_IDLE;
        endcase
      end
    endcase
  end

endmodule

>>> rtl/serial_command_line_parser_top.sv
`timescale 1ns / 1ps

// Serial command line parser. Each received character gives exactly one result,
// which echoes the character and carries the action it completes (if any) in
// tuser. The block takes one character per clock while s_tready is high: the
// parser state updates and the result register loads in the cycle a character
// is accepted, so its result appears in the next cycle; s_tready stays high
// while the result register is empty or being drained. Letters t, d, b, w, r
// open a command in idle, digits build a 16-bit decimal value, CR or LF ends it.

module serial_command_line_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // echo_byte, action_value, sensor_addr, sensor_data
  output logic [2:0]  m_tuser    // action
);

  sclp_pkg::parse_state_t  state;
  sclp_pkg::parse_state_t  state_next;
  sclp_pkg::parse_result_t result;
  sclp_pkg::parse_result_t result_next;
  logic                    s_accept;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  sclp_step u_step (
    .cur     (state),
    .rx_byte (s_tdata),
    .nxt     (state_next),
    .res     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode <= sclp_pkg::MODE_IDLE;
      state.acc  <= '0;
      state.pend <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s_accept) begin
        state    <= state_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      result <= result_next;
    end
  end

  assign m_tdata = {result.sensor_data, result.sensor_addr, result.action_value,
                    result.echo_byte};
  assign m_tuser = result.action;

`ifndef ASSERT_OFF
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow output register occupancy");

  a_echo: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> m_tvalid && (m_tdata[7:0] == $past(s_tdata)))
    else $error("result does not echo the accepted character");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == sclp_pkg::ACT_NONE)) |-> (m_tdata[39:8] == '0))
    else $error("result without action carries nonzero payload");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (result_next.action != sclp_pkg::ACT_NONE))
      |=> (state.mode == sclp_pkg::MODE_IDLE) && (state.acc == '0))
    else $error("closing a command did not return to idle with value cleared");
`endif

endmodule
